// ===== rtl/pressure_temperature_compensation_macros.svh =====
// Assertion helpers for the compensation block; clk and rst_n must be in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } ptc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [19:0]        pressure_pa;
        logic               divisor_zero;
    } ptc_out_t;

    // side data that rides along the quotient pipeline
    typedef struct packed {
        logic [15:0] temp;
        logic        neg;
        logic        dz;
    } ptc_tag_t;

    typedef enum logic [1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } ptc_cfg_e;

    localparam int DIV_STAGES = 64;
    localparam int PIPE_LAST  = 85;

    localparam logic [31:0] TEMP_MUL   = 32'd5;
    localparam logic [31:0] TEMP_ROUND = 32'd128;
    localparam logic [63:0] FINE_OFFS  = 64'd128000;
    localparam logic [20:0] PRESS_FULL = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] V1_BIAS    = 64'd1 << 47;
    localparam logic [63:0] PRESS_MAX  = 64'hF_FFFF;
    localparam logic [63:0] NEG_ROUND  = 64'd255;
    localparam int SH_P4 = 35;
    localparam int SH_V1 = 33;
    localparam int SH_P  = 31;

    function automatic logic [31:0] asr32(logic [31:0] v, int unsigned s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int unsigned s);
        logic signed [63:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

endpackage

// ===== rtl/ptc_mul.sv =====
// 64x64 product modulo 2^64: 32-bit partial products are registered, then their sum is registered.
module ptc_mul
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] y
);

    logic [63:0] pll_next;
    logic [31:0] plh_next;
    logic [31:0] phl_next;
    logic [63:0] pll_reg;
    logic [31:0] plh_reg;
    logic [31:0] phl_reg;
    logic [63:0] y_reg;

    assign pll_next = a[31:0] * b[31:0];
    assign plh_next = a[31:0] * b[63:32];
    assign phl_next = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            y_reg   <= pll_reg + {plh_reg + phl_reg, 32'd0};
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/ptc_div.sv =====
// Unsigned restoring divider, one quotient bit per stage.
module ptc_div
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    input  ptc_tag_t    tag_in,
    output logic [63:0] quotient,
    output ptc_tag_t    tag_out
);

    logic [63:0] rem_reg [DIV_STAGES];
    logic [63:0] nq_reg  [DIV_STAGES];
    logic [63:0] dvs_reg [DIV_STAGES];
    ptc_tag_t    tag_reg [DIV_STAGES];

    genvar g;
    for (g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [63:0] rin;
        logic [63:0] nin;
        logic [63:0] din;
        ptc_tag_t    tin;
        logic [64:0] trial;
        logic        ge;

        if (g == 0)
        begin : g_first
            assign rin = '0;
            assign nin = dividend;
            assign din = divisor;
            assign tin = tag_in;
        end
        else
        begin : g_rest
            assign rin = rem_reg[g-1];
            assign nin = nq_reg[g-1];
            assign din = dvs_reg[g-1];
            assign tin = tag_reg[g-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign trial = {rin, nin[63]};
        assign ge    = trial >= {1'b0, din};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= ge ? 64'(trial - {1'b0, din}) : trial[63:0];
                nq_reg[g]  <= {nin[62:0], ge};
                dvs_reg[g] <= din;
                tag_reg[g] <= tin;
            end
        end
    end

    assign quotient = nq_reg[DIV_STAGES-1];
    assign tag_out  = tag_reg[DIV_STAGES-1];

endmodule

// ===== rtl/pressure_temperature_compensation.sv =====
// Channel | Signals                          | Direction | Payload
// --------+----------------------------------+-----------+-------------------------------
// in      | in_valid, in_stall, in_data      | to block  | raw temperature, raw pressure
// out     | out_valid, out_stall, out_data   | from block| centi-degC, Pa, divisor zero
// cfg     | cfg_we, cfg_index, cfg_data      | to block  | calibration coefficient words
//
// One item per cycle sustained while the skid register is empty; out_valid follows acceptance through
// the 64-stage quotient pipeline plus the 64-bit multiply stages around it.
// rst_n (async, low) clears the pipeline, output and skid valid bits and the coefficients.
// The pipeline freezes only while the skid register is full; in_stall is that flag,
// so an output stall reaches the input only once it has filled the skid register, and no item is lost.
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ptc_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ptc_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // ---------------- calibration registers ----------------
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_coeffs_a_reg;
    logic [63:0] press_coeffs_b_reg;
    logic [15:0] press_coeff_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg    <= '0;
            press_coeffs_a_reg <= '0;
            press_coeffs_b_reg <= '0;
            press_coeff_c_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ptc_cfg_e'(cfg_index))
                CFG_TEMP:    temp_coeffs_reg    <= cfg_data[47:0];
                CFG_PRESS_A: press_coeffs_a_reg <= cfg_data;
                CFG_PRESS_B: press_coeffs_b_reg <= cfg_data;
                CFG_PRESS_C: press_coeff_c_reg  <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // coefficient slices; the user must keep config stable while items are in flight (not enforced here)
    logic [15:0] t1;
    logic [31:0] t2_32;
    logic [31:0] t3_32;
    logic [63:0] p1_64, p2_64, p3_64, p4_64, p5_64, p6_64, p7_64, p8_64, p9_64;

    assign t1    = temp_coeffs_reg[15:0];
    assign t2_32 = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3_32 = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
    assign p1_64 = {48'd0, press_coeffs_a_reg[15:0]};
    assign p2_64 = {{48{press_coeffs_a_reg[31]}}, press_coeffs_a_reg[31:16]};
    assign p3_64 = {{48{press_coeffs_a_reg[47]}}, press_coeffs_a_reg[47:32]};
    assign p4_64 = {{48{press_coeffs_a_reg[63]}}, press_coeffs_a_reg[63:48]};
    assign p5_64 = {{48{press_coeffs_b_reg[15]}}, press_coeffs_b_reg[15:0]};
    assign p6_64 = {{48{press_coeffs_b_reg[31]}}, press_coeffs_b_reg[31:16]};
    assign p7_64 = {{48{press_coeffs_b_reg[47]}}, press_coeffs_b_reg[47:32]};
    assign p8_64 = {{48{press_coeffs_b_reg[63]}}, press_coeffs_b_reg[63:48]};
    assign p9_64 = {{48{press_coeff_c_reg[15]}}, press_coeff_c_reg};

    // ---------------- pipeline control ----------------
    logic             en;
    logic             accept;
    logic [PIPE_LAST:0] vld_reg;
    logic             skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign accept   = in_valid && en;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAST-1:0], accept};
    end

    // ---------------- temperature, 32-bit wrapping ----------------
    ptc_in_t     in_reg;
    logic [31:0] s1_tx_reg, s1_dd_reg;
    logic [31:0] s2_a_reg, s2_b1_reg;
    logic [31:0] s3_fine_reg;
    logic [63:0] s4_v1_reg;
    logic [15:0] temp_reg [4:12];
    logic [20:0] pd_reg [1:9];

    logic [31:0] x32, d32, tc;
    logic [15:0] temp_sat;

    always_comb
    begin
        x32 = {15'd0, in_reg.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
        d32 = {16'd0, in_reg.raw_temperature[19:4]} - {16'd0, t1};
        tc  = asr32(s3_fine_reg * TEMP_MUL + TEMP_ROUND, 8);
        // clamp to the signed 16-bit range
        if (tc[31] && (tc < 32'hFFFF_8000))
            temp_sat = 16'h8000;
        else if (!tc[31] && (tc > 32'd32767))
            temp_sat = 16'h7FFF;
        else
            temp_sat = tc[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg      <= in_data;
            s1_tx_reg   <= x32 * t2_32;
            s1_dd_reg   <= d32 * d32;
            pd_reg[1]   <= PRESS_FULL - {1'b0, in_reg.raw_pressure};
            s2_a_reg    <= asr32(s1_tx_reg, 11);
            s2_b1_reg   <= asr32(s1_dd_reg, 12) * t3_32;
            s3_fine_reg <= s2_a_reg + asr32(s2_b1_reg, 14);
            temp_reg[4] <= temp_sat;
            s4_v1_reg   <= {{32{s3_fine_reg[31]}}, s3_fine_reg} - FINE_OFFS;
            for (int k = 5; k <= 12; k++)
                temp_reg[k] <= temp_reg[k-1];
            for (int k = 2; k <= 9; k++)
                pd_reg[k] <= pd_reg[k-1];
        end
    end

    // ---------------- pressure divisor and dividend, 64-bit wrapping ----------------
    logic [63:0] mul_a_y, mul_b_y, mul_c_y, mul_d_y, mul_e_y, mul_f_y, mul_g_y;
    logic [63:0] s7_v1p5_reg, s7_v1p2_reg, s8_v1p5_reg, s8_v1p2_reg;
    logic [63:0] s9_v2_reg, s9_t_reg, s10_diff_reg, s12_dvs_reg;
    logic [63:0] e_sh;

    // v1^2, v1*P5, v1*P2
    ptc_mul u_mul_a (.clk(clk), .en(en), .a(s4_v1_reg), .b(s4_v1_reg), .y(mul_a_y));
    ptc_mul u_mul_b (.clk(clk), .en(en), .a(s4_v1_reg), .b(p5_64),     .y(mul_b_y));
    ptc_mul u_mul_c (.clk(clk), .en(en), .a(s4_v1_reg), .b(p2_64),     .y(mul_c_y));
    // v1^2*P6, v1^2*P3
    ptc_mul u_mul_d (.clk(clk), .en(en), .a(mul_a_y),   .b(p6_64),     .y(mul_d_y));
    ptc_mul u_mul_e (.clk(clk), .en(en), .a(mul_a_y),   .b(p3_64),     .y(mul_e_y));
    // (2^47 + v1) * P1 gives the divisor, diff * 3125 the dividend
    ptc_mul u_mul_f (.clk(clk), .en(en), .a(s9_t_reg),  .b(p1_64),     .y(mul_f_y));
    ptc_mul u_mul_g (.clk(clk), .en(en), .a(s10_diff_reg), .b(PRESS_SCALE), .y(mul_g_y));

    assign e_sh = asr64(mul_e_y, 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_v1p5_reg  <= mul_b_y;
            s7_v1p2_reg  <= mul_c_y;
            s8_v1p5_reg  <= s7_v1p5_reg;
            s8_v1p2_reg  <= s7_v1p2_reg;
            s9_v2_reg    <= mul_d_y + (s8_v1p5_reg << 17) + (p4_64 << SH_P4);
            s9_t_reg     <= e_sh + (s8_v1p2_reg << 12) + V1_BIAS;
            s10_diff_reg <= ({43'd0, pd_reg[9]} << SH_P) - s9_v2_reg;
            s12_dvs_reg  <= asr64(mul_f_y, SH_V1);
        end
    end

    // ---------------- signed division ----------------
    logic [63:0] div_ua_reg, div_ub_reg, div_q;
    ptc_tag_t    div_tag_reg, div_tag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_ua_reg <= mul_g_y[63] ? 64'(0 - mul_g_y) : mul_g_y;
            div_ub_reg <= s12_dvs_reg[63] ? 64'(0 - s12_dvs_reg) : s12_dvs_reg;
            div_tag_reg.temp <= temp_reg[12];
            div_tag_reg.neg  <= mul_g_y[63] ^ s12_dvs_reg[63];
            div_tag_reg.dz   <= (s12_dvs_reg == '0);
        end
    end

    ptc_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (div_ua_reg),
        .divisor  (div_ub_reg),
        .tag_in   (div_tag_reg),
        .quotient (div_q),
        .tag_out  (div_tag)
    );

    // ---------------- pressure tail ----------------
    logic [63:0] q_reg [78:82];
    ptc_tag_t    tail_reg [78:84];
    logic [63:0] v2_reg [81:82];
    logic [63:0] sum_reg, p_reg;
    logic [63:0] mul_h_y, mul_i_y, mul_j_y;
    logic [63:0] q78_sh, q80_sh, j_sh, sum_sh, p_div, i_sh;
    ptc_out_t    res_reg, res_next;

    assign q78_sh = asr64(q_reg[78], 13);
    assign q80_sh = asr64(q_reg[80], 13);
    assign j_sh   = asr64(mul_j_y, 25);
    assign i_sh   = asr64(mul_i_y, 19);
    assign sum_sh = asr64(sum_reg, 8);

    ptc_mul u_mul_h (.clk(clk), .en(en), .a(q78_sh),  .b(p9_64),  .y(mul_h_y));
    ptc_mul u_mul_i (.clk(clk), .en(en), .a(q_reg[78]), .b(p8_64), .y(mul_i_y));
    ptc_mul u_mul_j (.clk(clk), .en(en), .a(mul_h_y), .b(q80_sh), .y(mul_j_y));

    always_comb
    begin
        // divide by 256 toward zero
        p_div = p_reg[63] ? asr64(p_reg + NEG_ROUND, 8) : (p_reg >> 8);
        res_next.temperature_centi = tail_reg[84].temp;
        res_next.divisor_zero      = tail_reg[84].dz;
        if (tail_reg[84].dz || p_div[63])
            res_next.pressure_pa = '0;
        else if (p_div > PRESS_MAX)
            res_next.pressure_pa = PRESS_MAX[19:0];
        else
            res_next.pressure_pa = p_div[19:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[78]    <= div_tag.neg ? 64'(0 - div_q) : div_q;
            tail_reg[78] <= div_tag;
            for (int k = 79; k <= 82; k++)
                q_reg[k] <= q_reg[k-1];
            for (int k = 79; k <= 84; k++)
                tail_reg[k] <= tail_reg[k-1];
            v2_reg[81] <= i_sh;
            v2_reg[82] <= v2_reg[81];
            sum_reg    <= q_reg[82] + j_sh + v2_reg[82];
            p_reg      <= sum_sh + (p7_64 << 4);
            res_reg    <= res_next;
        end
    end

    // ---------------- output register with skid ----------------
    logic     out_valid_reg, out_valid_next, skid_valid_next;
    ptc_out_t out_data_reg, out_data_next, skid_data_reg, skid_data_next;
    logic     take, push;

    assign take = out_valid_reg && !out_stall;
    assign push = vld_reg[PIPE_LAST] && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = res_reg;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res_reg;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- checks ----------------
    `PTC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `PTC_ASSERT_NOW(a_dz_press_zero, out_valid_reg && out_data_reg.divisor_zero, out_data_reg.pressure_pa == '0, "zero divisor with nonzero pressure")
    `PTC_ASSERT_NEXT(a_freeze_on_skid, skid_valid_reg, $stable(vld_reg), "pipeline moved while skid full")

endmodule

// ===== bench/pressure_temperature_compensation_test.sv =====
`timescale 1ns / 1ps

module pressure_temperature_compensation_test;
    import ptc_pkg::*;

    // Leave margin before touching coefficients or ending.
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 300;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int QUIET_ITEMS   = 200;
    localparam int RESET_ROWS    = 6;
    localparam int TABLE_ROWS    = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    ptc_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    ptc_out_t    out_data;
    logic        cfg_we;
    ptc_cfg_e    cfg_index;
    logic [63:0] cfg_data;

    pressure_temperature_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the calibration words, as last written.
    logic [47:0] temp_word;
    logic [63:0] press_word_a;
    logic [63:0] press_word_b;
    logic [15:0] press_word_c;

    ptc_out_t reading_q[$];
    int       fail_count;
    bit       quiet;     // no idling on either side
    bit       hold_req;  // ask receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [31:0] sra32(logic [31:0] v, int s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] v, int s);
        logic signed [63:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    // signed divide of bit patterns, truncating toward zero
    function automatic logic [63:0] sdiv_trunc(logic [63:0] a, logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q  = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] sext16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Compensated reading for one raw sample pair under the shadow coefficients.
    function automatic ptc_out_t compensate(ptc_in_t x);
        ptc_out_t    r;
        logic [31:0] adc_t, t1, t2, t3, a, d, b, fine, tc;
        logic [63:0] v1, v2, p, q, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        adc_t = {12'd0, x.raw_temperature};
        t1 = {16'd0, temp_word[15:0]};
        t2 = 32'(sext16(temp_word[31:16]));
        t3 = 32'(sext16(temp_word[47:32]));
        p1 = {48'd0, press_word_a[15:0]};
        p2 = sext16(press_word_a[31:16]);
        p3 = sext16(press_word_a[47:32]);
        p4 = sext16(press_word_a[63:48]);
        p5 = sext16(press_word_b[15:0]);
        p6 = sext16(press_word_b[31:16]);
        p7 = sext16(press_word_b[47:32]);
        p8 = sext16(press_word_b[63:48]);
        p9 = sext16(press_word_c);

        // fine temperature, 32-bit wrap
        a = (adc_t >> 3) - (t1 << 1);
        a = a * t2;
        a = sra32(a, 11);
        d = (adc_t >> 4) - t1;
        b = d * d;
        b = sra32(b, 12);
        b = b * t3;
        b = sra32(b, 14);
        fine = a + b;
        tc = fine * 32'd5 + 32'd128;
        tc = sra32(tc, 8);
        if ($signed(tc) < -32768)
            r.temperature_centi = 16'sh8000;
        else if ($signed(tc) > 32767)
            r.temperature_centi = 16'sh7FFF;
        else
            r.temperature_centi = tc[15:0];

        // pressure, 64-bit wrap
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1;
        v2 = v2 * p6;
        q  = v1 * p5;
        v2 = v2 + (q << 17);
        v2 = v2 + (p4 << 35);
        q  = v1 * v1;
        q  = sra64(q * p3, 8);
        v1 = v1 * p2;
        v1 = q + (v1 << 12);
        v1 = ((64'd1 << 47) + v1) * p1;
        v1 = sra64(v1, 33);

        if (v1 == 64'd0)
        begin
            r.pressure_pa  = '0;
            r.divisor_zero = 1'b1;
        end
        else
        begin
            r.divisor_zero = 1'b0;
            p  = 64'd1048576 - {44'd0, x.raw_pressure};
            p  = ((p << 31) - v2) * 64'd3125;
            p  = sdiv_trunc(p, v1);
            q  = sra64(p, 13);
            v1 = p9 * q;
            v1 = sra64(v1 * q, 25);
            v2 = sra64(p8 * p, 19);
            p  = sra64(p + v1 + v2, 8) + (p7 << 4);
            p  = sdiv_trunc(p, 64'd256);
            if (p[63])
                r.pressure_pa = '0;
            else if (p > 64'hF_FFFF)
                r.pressure_pa = 20'hF_FFFF;
            else
                r.pressure_pa = p[19:0];
        end
        return r;
    endfunction

    // Scoreboard: predict on input acceptance, compare on output acceptance.
    always @(posedge clk)
    begin
        ptc_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                reading_q.push_back(compensate(in_data));
            if (out_valid && !out_stall)
            begin
                if (reading_q.size() == 0)
                begin
                    $display("%0t: unexpected item %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (out_data.temperature_centi !== want.temperature_centi)
                    begin
                        $display("%0t: temperature_centi expected %0d actual %0d", $time,
                                 want.temperature_centi, out_data.temperature_centi);
                        fail_count++;
                    end
                    if (out_data.pressure_pa !== want.pressure_pa)
                    begin
                        $display("%0t: pressure_pa expected %0d actual %0d", $time,
                                 want.pressure_pa, out_data.pressure_pa);
                        fail_count++;
                    end
                    if (out_data.divisor_zero !== want.divisor_zero)
                    begin
                        $display("%0t: divisor_zero expected %0b actual %0b", $time,
                                 want.divisor_zero, out_data.divisor_zero);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_stall <= 1'b0;
            else if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item; valid stays high into the next item unless a gap is drawn.
    task automatic send_sample(ptc_in_t x);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Sender pause until every expected item is back, then let the pipe empty.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Holds the write enable high; the caller drops it after the last word.
    task automatic write_reg(ptc_cfg_e idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            CFG_TEMP:    temp_word    = val[47:0];
            CFG_PRESS_A: press_word_a = val;
            CFG_PRESS_B: press_word_b = val;
            CFG_PRESS_C: press_word_c = val[15:0];
        endcase
    endtask

    task automatic load_coeffs(logic [47:0] tw, logic [63:0] pa, logic [63:0] pb,
                               logic [15:0] pc);
        write_reg(CFG_TEMP, {16'd0, tw});
        write_reg(CFG_PRESS_A, pa);
        write_reg(CFG_PRESS_B, pb);
        write_reg(CFG_PRESS_C, {48'd0, pc});
        cfg_we <= 1'b0;
    endtask

    // Typical factory calibration: T1..T3, P1..P9.
    localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PA   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PB   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] TYP_PC   = 16'd6000;

    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          typed;
        ptc_out_t    want;
    } table_row_t;

    table_row_t stim_table[TABLE_ROWS];

    initial
    begin
        ptc_in_t    x;
        ptc_out_t   got;
        int         sel;
        logic [63:0] r1, r2;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        fail_count = 0;
        temp_word = '0;
        press_word_a = '0;
        press_word_b = '0;
        press_word_c = '0;

        // After reset all coefficients are zero: temperature 0, divisor zero.
        stim_table[0] = '{20'd0,       20'd0,       1, '{16'sd0, 20'd0, 1'b1}};
        stim_table[1] = '{20'hF_FFFF,  20'hF_FFFF,  1, '{16'sd0, 20'd0, 1'b1}};
        stim_table[2] = '{20'd519888,  20'd415148,  1, '{16'sd0, 20'd0, 1'b1}};
        stim_table[3] = '{20'hA_AAAA,  20'h5_5555,  1, '{16'sd0, 20'd0, 1'b1}};
        stim_table[4] = '{20'h5_5555,  20'hA_AAAA,  1, '{16'sd0, 20'd0, 1'b1}};
        stim_table[5] = '{20'h8_0000,  20'h0_0001,  1, '{16'sd0, 20'd0, 1'b1}};
        // typical coefficients from here on
        stim_table[6]  = '{20'd519888, 20'd415148, 0, '{default: '0}};
        stim_table[7]  = '{20'd0,      20'd0,      0, '{default: '0}};
        stim_table[8]  = '{20'hF_FFFF, 20'hF_FFFF, 0, '{default: '0}};
        stim_table[9]  = '{20'd0,      20'hF_FFFF, 0, '{default: '0}};
        stim_table[10] = '{20'hF_FFFF, 20'd0,      0, '{default: '0}};
        stim_table[11] = '{20'd440064, 20'd1,      0, '{default: '0}};
        stim_table[12] = '{20'd440064, 20'd1048575, 0, '{default: '0}};
        stim_table[13] = '{20'd600000, 20'd300000, 0, '{default: '0}};
        stim_table[14] = '{20'd400000, 20'd700000, 0, '{default: '0}};
        stim_table[15] = '{20'd8,      20'd524288, 0, '{default: '0}};
        stim_table[16] = '{20'd1048560, 20'd2,     0, '{default: '0}};
        stim_table[17] = '{20'd527000, 20'd1000,   0, '{default: '0}};
        stim_table[18] = '{20'd512000, 20'd900000, 0, '{default: '0}};
        stim_table[19] = '{20'd475000, 20'd415148, 0, '{default: '0}};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: typed rows are checked here against the model; the scoreboard checks every row.
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            if (i == RESET_ROWS)
            begin
                drain_pipe();
                load_coeffs(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
            end
            x.raw_temperature = stim_table[i].raw_t;
            x.raw_pressure    = stim_table[i].raw_p;
            if (stim_table[i].typed)
            begin
                got = compensate(x);
                if (got !== stim_table[i].want)
                begin
                    $display("%0t: row %0d expected %h actual %h", $time, i,
                             stim_table[i].want, got);
                    fail_count++;
                end
            end
            send_sample(x);
        end
        drain_pipe();

        // Random phases, each under its own coefficient set.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            r1 = {$urandom, $urandom};
            r2 = {$urandom, $urandom};
            case (ph)
                0: load_coeffs(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
                1: load_coeffs(TYP_TEMP ^ {3{12'd0, 4'(r1[3:0])}},
                               TYP_PA ^ {4{12'd0, 4'(r1[7:4])}},
                               TYP_PB ^ {4{12'd0, 4'(r1[11:8])}}, TYP_PC ^ r1[27:12]);
                2: load_coeffs(r1[47:0], r2, {$urandom, $urandom}, r1[63:48]);
                // P1 zero: divisor zero on every item
                3: load_coeffs(TYP_TEMP, {TYP_PA[63:16], 16'd0}, TYP_PB, TYP_PC);
                4: load_coeffs('1, '1, '1, '1);
                5: load_coeffs({16'h8000, 16'h7FFF, 16'hFFFF},
                               {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
                6: load_coeffs({TYP_TEMP[47:16], r1[15:0]}, {TYP_PA[63:16], r2[15:0]},
                               r2, r1[31:16]);
                default: load_coeffs(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
            endcase
            if (ph == 1)
                hold_req = 1'b1;  // long output hold-off while items keep coming
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == RAND_PHASES - 1 && k == PHASE_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                if (ph == 0 && k == PHASE_ITEMS / 2)
                    drain_pipe();  // sender pause mid-phase
                sel = $urandom_range(0, 9);
                if (sel < 7)
                begin
                    x.raw_temperature = 20'($urandom_range(400000, 620000));
                    x.raw_pressure    = 20'($urandom_range(150000, 750000));
                end
                else
                begin
                    x.raw_temperature = 20'($urandom);
                    x.raw_pressure    = 20'($urandom);
                end
                send_sample(x);
            end
            if (ph != RAND_PHASES - 1)
                drain_pipe();
        end

        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (reading_q.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, reading_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== pressure_temperature_compensation.f =====
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation.sv
bench/pressure_temperature_compensation_test.sv
